// ===== rtl/core/rtc_pkg.sv =====
// Shared types, register codes and calendar functions for the real-time clock calendar.
`default_nettype none

package rtc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_HOUR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_MINUTE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIME_ENABLE = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [5:0] new_second;
      logic [5:0] new_minute;
      logic [4:0] new_hour;
      logic [4:0] new_day;
      logic [3:0] new_month;
      logic [6:0] new_year;
   } req_type;

   typedef struct packed {
      logic [5:0] cur_second;
      logic [5:0] cur_minute;
      logic [4:0] cur_hour;
      logic [4:0] cur_day;
      logic [3:0] cur_month;
      logic [6:0] cur_year;
      logic [2:0] cur_weekday;
      logic       pm_flag;
      logic       hour_chime;
      logic       alarm_match;
   } rsp_type;

   // Length of a month; every fourth year has a long February.
   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [6:0] year);
      logic [4:0] len;
      case (month) inside
         4'd2:                   len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the first of the month in a common year, reduced modulo seven.
   function automatic logic [2:0] days_before_mod7(input logic [3:0] month);
      logic [2:0] r;
      case (month)
         4'd2:    r = 3'd3;
         4'd3:    r = 3'd3;
         4'd4:    r = 3'd6;
         4'd5:    r = 3'd1;
         4'd6:    r = 3'd4;
         4'd7:    r = 3'd6;
         4'd8:    r = 3'd2;
         4'd9:    r = 3'd5;
         4'd11:   r = 3'd3;
         4'd12:   r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Weekday of a checked date, Saturday being zero. Since 8 and 64 are both
   // one modulo seven, the octal digits of the day count are summed twice.
   function automatic logic [2:0] weekday_of(input logic [4:0] day,
                                             input logic [3:0] month,
                                             input logic [6:0] year);
      logic [7:0] year_w;
      logic [7:0] leap_days;
      logic [7:0] leap_adj;
      logic [7:0] sum;
      logic [4:0] fold1;
      logic [3:0] fold2;
      year_w    = {1'b0, year};
      leap_days = (year_w + 8'd3) >> 2;
      leap_adj  = ((month > 4'd2) && (year[1:0] == 2'd0)) ? 8'd1 : 8'd0;
      sum       = year_w + leap_days + 8'(days_before_mod7(month)) + leap_adj
                  + 8'(day) - 8'd1;
      fold1     = 5'(sum[7:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
      fold2     = 4'(fold1[4:3]) + 4'(fold1[2:0]);
      return (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtc_calendar_counter.sv =====
// A word accepted into the input register is processed once the result register is
// free or being emptied; its result is then offered until the sink takes it.
// Throughput: one word per cycle unless the sink stalls; the input and result
// registers let a new word enter while a finished result still waits to be taken.
// Reset: synchronous; time 00:00:00, 1 January 2000 (a Saturday), alarm at 08:00,
// chime off, both stages empty.
`default_nettype none

module rtc_calendar_counter (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  rtc_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output rtc_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire  [rtc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [rtc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic             in_vld_ff;
   rtc_pkg::req_type in_data_ff;
   logic             rsp_vld_ff;
   rtc_pkg::rsp_type rsp_data_ff;

   logic [4:0] wake_hour_ff;
   logic [5:0] wake_min_ff;
   logic       chime_en_ff;

   logic [5:0] sec_ff,   sec_in;
   logic [5:0] min_ff,   min_in;
   logic [4:0] hour_ff,  hour_in;
   logic [4:0] day_ff,   day_in;
   logic [3:0] month_ff, month_in;
   logic [6:0] year_ff,  year_in;
   logic [2:0] wday_ff,  wday_in;
   logic       chime;

   logic       advance;
   logic       req_fire;

   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic [5:0] day_inc;
   logic [4:0] month_inc;
   logic [7:0] year_inc;
   logic [3:0] wday_inc;
   logic [4:0] dim_cur;

   logic [5:0] sec_set;
   logic [5:0] min_set;
   logic [4:0] hour_set;
   logic [4:0] day_set;
   logic [3:0] month_set;
   logic [6:0] year_set;
   logic [4:0] dim_set;

   // The processing stage moves when the result register is free or being emptied.
   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   assign sec_inc   = {1'b0, sec_ff} + 7'd1;
   assign min_inc   = {1'b0, min_ff} + 7'd1;
   assign hour_inc  = {1'b0, hour_ff} + 6'd1;
   assign day_inc   = {1'b0, day_ff} + 6'd1;
   assign month_inc = {1'b0, month_ff} + 5'd1;
   assign year_inc  = {1'b0, year_ff} + 8'd1;
   assign wday_inc  = {1'b0, wday_ff} + 4'd1;
   assign dim_cur   = rtc_pkg::days_in_month(month_ff, year_ff);

   // The year is clamped before the day is checked against February.
   assign sec_set   = (in_data_ff.new_second >= 6'd60) ? 6'd0 : in_data_ff.new_second;
   assign min_set   = (in_data_ff.new_minute >= 6'd60) ? 6'd0 : in_data_ff.new_minute;
   assign hour_set  = (in_data_ff.new_hour >= 5'd24) ? 5'd0 : in_data_ff.new_hour;
   assign month_set = ((in_data_ff.new_month == 4'd0) || (in_data_ff.new_month > 4'd12))
                      ? 4'd1 : in_data_ff.new_month;
   assign year_set  = (in_data_ff.new_year > 7'd99) ? 7'd0 : in_data_ff.new_year;
   assign dim_set   = rtc_pkg::days_in_month(month_set, year_set);
   assign day_set   = ((in_data_ff.new_day == 5'd0) || (in_data_ff.new_day > dim_set))
                      ? 5'd1 : in_data_ff.new_day;

   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      wday_in  = wday_ff;
      chime    = 1'b0;
      if (in_data_ff.op == rtc_pkg::OP_TICK) begin
         if (sec_inc >= 7'd60) begin
            sec_in = 6'd0;
            if (min_inc >= 7'd60) begin
               min_in = 6'd0;
               chime  = chime_en_ff;
               if (hour_inc >= 6'd24) begin
                  hour_in = 5'd0;
                  wday_in = (wday_inc >= 4'd7) ? 3'd0 : wday_inc[2:0];
                  if (day_inc > {1'b0, dim_cur}) begin
                     day_in = 5'd1;
                     if (month_inc > 5'd12) begin
                        month_in = 4'd1;
                        year_in  = (year_inc > 8'd99) ? 7'd0 : year_inc[6:0];
                     end else begin
                        month_in = month_inc[3:0];
                     end
                  end else begin
                     day_in = day_inc[4:0];
                  end
               end else begin
                  hour_in = hour_inc[4:0];
               end
            end else begin
               min_in = min_inc[5:0];
            end
         end else begin
            sec_in = sec_inc[5:0];
         end
      end else begin
         sec_in   = sec_set;
         min_in   = min_set;
         hour_in  = hour_set;
         day_in   = day_set;
         month_in = month_set;
         year_in  = year_set;
         wday_in  = rtc_pkg::weekday_of(day_set, month_set, year_set);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         wake_hour_ff  <= 5'd8;
         wake_min_ff   <= 6'd0;
         chime_en_ff   <= 1'b0;
         sec_ff        <= 6'd0;
         min_ff        <= 6'd0;
         hour_ff       <= 5'd0;
         day_ff        <= 5'd1;
         month_ff      <= 4'd1;
         year_ff       <= 7'd0;
         wday_ff       <= 3'd0;
      end else begin
         if (!in_vld_ff || advance) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         if (advance) begin
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
            wday_ff  <= wday_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               rtc_pkg::CSR_ALARM_HOUR:   wake_hour_ff <= csr_wdata[4:0];
               rtc_pkg::CSR_ALARM_MINUTE: wake_min_ff  <= csr_wdata;
               rtc_pkg::CSR_CHIME_ENABLE: chime_en_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.cur_second  <= sec_in;
         rsp_data_ff.cur_minute  <= min_in;
         rsp_data_ff.cur_hour    <= hour_in;
         rsp_data_ff.cur_day     <= day_in;
         rsp_data_ff.cur_month   <= month_in;
         rsp_data_ff.cur_year    <= year_in;
         rsp_data_ff.cur_weekday <= wday_in;
         rsp_data_ff.pm_flag     <= (hour_in >= 5'd12);
         rsp_data_ff.hour_chime  <= chime;
         rsp_data_ff.alarm_match <= (hour_in == wake_hour_ff) && (min_in == wake_min_ff);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rtc_checker.sv =====
// Port-level checks for the real-time clock calendar and their attachment to it.
`default_nettype none

module rtc_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire rtc_pkg::rsp_type rsp_data
);

   // A word held back by the sink stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word was dropped or changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pm_flag == (rsp_data.cur_hour >= 5'd12)))
      else $error("pm flag disagrees with the hour");

   // The chime can only come on the tick that lands on the full hour.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hour_chime |->
         (rsp_data.cur_second == 6'd0) && (rsp_data.cur_minute == 6'd0))
      else $error("chime raised away from the hour boundary");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_second < 6'd60) && (rsp_data.cur_minute < 6'd60)
         && (rsp_data.cur_hour < 5'd24) && (rsp_data.cur_month != 4'd0)
         && (rsp_data.cur_month < 4'd13) && (rsp_data.cur_day != 5'd0)
         && (rsp_data.cur_year < 7'd100) && (rsp_data.cur_weekday < 3'd7))
      else $error("time or date field out of range");

endmodule

bind rtc_calendar_counter rtc_checker u_rtc_checker (.*);

`default_nettype wire

// ===== tb/tb_rtc_calendar_counter.sv =====
// Self-checking testbench for the real-time clock calendar counter.
`timescale 1ns / 1ps

class calendar_scoreboard;
   // Mirror of the calendar and its alarm registers.
   bit [5:0] second;
   bit [5:0] minute;
   bit [4:0] hour;
   bit [4:0] day;
   bit [3:0] month;
   bit [6:0] year;
   bit [2:0] weekday;
   bit [4:0] wake_hour;
   bit [5:0] wake_minute;
   bit       chime_enable;

   rtc_pkg::rsp_type expected_times[$];
   int unsigned      error_count;

   function new();
      second       = '0;
      minute       = '0;
      hour         = '0;
      day          = 5'd1;
      month        = 4'd1;
      year         = '0;
      weekday      = '0;
      wake_hour    = 5'd8;
      wake_minute  = '0;
      chime_enable = 1'b0;
      error_count  = 0;
   endfunction

   function int unsigned month_length(int unsigned mo, int unsigned yr);
      case (mo)
         2:             return (yr % 4 == 0) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // Days since 1 January 2000 taken modulo seven; that date was a Saturday.
   function bit [2:0] weekday_of_date(int unsigned d, int unsigned mo, int unsigned yr);
      int unsigned days;
      days = yr * 365 + (yr + 3) / 4 + d - 1;
      for (int unsigned m = 1; m < mo; m++)
         days += month_length(m, yr);
      return 3'(days % 7);
   endfunction

   function void write_register(logic [rtc_pkg::CSR_INDEX_W-1:0] index,
                                logic [rtc_pkg::CSR_DATA_W-1:0] data);
      case (index)
         rtc_pkg::CSR_ALARM_HOUR:   wake_hour    = data[4:0];
         rtc_pkg::CSR_ALARM_MINUTE: wake_minute  = data[5:0];
         rtc_pkg::CSR_CHIME_ENABLE: chime_enable = data[0];
         default: ;
      endcase
   endfunction

   function void accept_request(rtc_pkg::req_type w);
      rtc_pkg::rsp_type r;
      bit               chime;
      int unsigned      s, mi, h, d, mo, yr;
      chime = 1'b0;
      if (w.op == rtc_pkg::OP_TICK) begin
         if (second == 6'd59) begin
            second = '0;
            if (minute == 6'd59) begin
               minute = '0;
               chime  = chime_enable;
               if (hour == 5'd23) begin
                  hour    = '0;
                  weekday = (weekday == 3'd6) ? 3'd0 : weekday + 3'd1;
                  if (day >= month_length(month, year)) begin
                     day = 5'd1;
                     if (month == 4'd12) begin
                        month = 4'd1;
                        year  = (year == 7'd99) ? 7'd0 : year + 7'd1;
                     end else begin
                        month = month + 4'd1;
                     end
                  end else begin
                     day = day + 5'd1;
                  end
               end else begin
                  hour = hour + 5'd1;
               end
            end else begin
               minute = minute + 6'd1;
            end
         end else begin
            second = second + 6'd1;
         end
      end else begin
         s  = w.new_second;
         mi = w.new_minute;
         h  = w.new_hour;
         d  = w.new_day;
         mo = w.new_month;
         yr = w.new_year;
         if (s >= 60) s = 0;
         if (mi >= 60) mi = 0;
         if (h >= 24) h = 0;
         if (mo == 0 || mo > 12) mo = 1;
         // The year is clamped first so that February uses the loaded year.
         if (yr > 99) yr = 0;
         if (d == 0 || d > month_length(mo, yr)) d = 1;
         second  = 6'(s);
         minute  = 6'(mi);
         hour    = 5'(h);
         day     = 5'(d);
         month   = 4'(mo);
         year    = 7'(yr);
         weekday = weekday_of_date(d, mo, yr);
      end
      r.cur_second  = second;
      r.cur_minute  = minute;
      r.cur_hour    = hour;
      r.cur_day     = day;
      r.cur_month   = month;
      r.cur_year    = year;
      r.cur_weekday = weekday;
      r.pm_flag     = (hour >= 5'd12);
      r.hour_chime  = chime;
      r.alarm_match = (hour == wake_hour) && (minute == wake_minute);
      expected_times.push_back(r);
   endfunction

   function int unsigned pending();
      return expected_times.size();
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function void check_time_report(rtc_pkg::rsp_type got);
      rtc_pkg::rsp_type want;
      if (expected_times.size() == 0) begin
         $error("result word arrived with nothing expected");
         error_count++;
         return;
      end
      want = expected_times.pop_front();
      compare_field("cur_second",  8'(want.cur_second),  8'(got.cur_second));
      compare_field("cur_minute",  8'(want.cur_minute),  8'(got.cur_minute));
      compare_field("cur_hour",    8'(want.cur_hour),    8'(got.cur_hour));
      compare_field("cur_day",     8'(want.cur_day),     8'(got.cur_day));
      compare_field("cur_month",   8'(want.cur_month),   8'(got.cur_month));
      compare_field("cur_year",    8'(want.cur_year),    8'(got.cur_year));
      compare_field("cur_weekday", 8'(want.cur_weekday), 8'(got.cur_weekday));
      compare_field("pm_flag",     8'(want.pm_flag),     8'(got.pm_flag));
      compare_field("hour_chime",  8'(want.hour_chime),  8'(got.hour_chime));
      compare_field("alarm_match", 8'(want.alarm_match), 8'(got.alarm_match));
   endfunction
endclass

module tb_rtc_calendar_counter;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned DRAIN_CYCLES  = 6;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_WORDS   = 138;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   rtc_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   rtc_pkg::rsp_type                rsp_data;
   logic                            csr_we    = 1'b0;
   logic [rtc_pkg::CSR_INDEX_W-1:0] csr_index = rtc_pkg::CSR_ALARM_HOUR;
   logic [rtc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   calendar_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned words_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned stall_mode  = 0;
   int unsigned mode_left   = 0;
   int unsigned run_left    = 0;

   rtc_calendar_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rtc_calendar_counter verification failed");
         $finish;
      end
   end

   // Result side: take words and switch between stall patterns every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_time_report(rsp_data);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: begin
               if (run_left == 0) begin
                  rsp_stall <= ~rsp_stall;
                  run_left = $urandom_range(1, 8);
               end else begin
                  run_left--;
               end
            end
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   function automatic rtc_pkg::req_type random_request();
      rtc_pkg::req_type w;
      w.op         = 1'($urandom_range(0, 1));
      w.new_second = 6'($urandom_range(0, 63));
      w.new_minute = 6'($urandom_range(0, 63));
      w.new_hour   = 5'($urandom_range(0, 31));
      w.new_day    = 5'($urandom_range(0, 31));
      w.new_month  = 4'($urandom_range(0, 15));
      w.new_year   = 7'($urandom_range(0, 127));
      return w;
   endfunction

   // Offer one word, opening a new burst after a random gap when the last one ran out.
   task automatic send_word(input rtc_pkg::req_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.accept_request(w);
      burst_left--;
      words_sent++;
   endtask

   task automatic send_tick();
      rtc_pkg::req_type w;
      w    = random_request();
      w.op = rtc_pkg::OP_TICK;
      send_word(w);
   endtask

   task automatic send_set(input int unsigned s, mi, h, d, mo, yr);
      rtc_pkg::req_type w;
      w.op         = rtc_pkg::OP_SET;
      w.new_second = 6'(s);
      w.new_minute = 6'(mi);
      w.new_hour   = 5'(h);
      w.new_day    = 5'(d);
      w.new_month  = 4'(mo);
      w.new_year   = 7'(yr);
      send_word(w);
   endtask

   // Lower valid at the edge of the last acceptance and wait for every result.
   task automatic wait_until_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rtc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rtc_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic program_alarm(input logic [rtc_pkg::CSR_DATA_W-1:0] hour_data,
                                input logic [rtc_pkg::CSR_DATA_W-1:0] minute_data,
                                input logic [rtc_pkg::CSR_DATA_W-1:0] chime_data);
      wait_until_drained();
      write_csr(rtc_pkg::CSR_ALARM_HOUR, hour_data);
      write_csr(rtc_pkg::CSR_ALARM_MINUTE, minute_data);
      write_csr(rtc_pkg::CSR_CHIME_ENABLE, chime_data);
      csr_we <= 1'b0;
   endtask

   // Load a time a few seconds short of a minute, often at the end of a day, month
   // or year, then tick towards the carry.
   task automatic send_rollover_run();
      int unsigned s, mi, h, d, mo, yr, len, ticks, pick;
      mo   = $urandom_range(1, 12);
      yr   = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
      pick = $urandom_range(0, 3);
      h    = (pick == 0) ? 23 : (pick == 1) ? 11 : (pick == 2) ? sb.wake_hour
                                                              : $urandom_range(0, 23);
      pick = $urandom_range(0, 9);
      mi   = (pick < 6) ? 59 : (pick < 8) ? sb.wake_minute : $urandom_range(0, 59);
      s    = $urandom_range(50, 59);
      len  = sb.month_length(mo, yr);
      d    = ($urandom_range(0, 99) < 60) ? len : $urandom_range(1, len);
      send_set(s, mi, h, d, mo, yr);
      ticks = $urandom_range(1, 15);
      repeat (ticks) send_tick();
   endtask

   task automatic run_random_phase(input int unsigned count);
      int unsigned target, pick;
      target = words_sent + count;
      while (words_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_rollover_run();
         end else if (pick < 85) begin
            send_word(random_request());
         end else begin
            repeat ($urandom_range(1, 5)) send_tick();
         end
      end
   endtask

   initial begin
      logic [rtc_pkg::CSR_DATA_W-1:0] hour_data, minute_data, chime_data;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: alarm at 08:00, chime off.
      send_tick();
      send_set(59, 59, 7, 1, 1, 0);
      send_tick();
      send_set(63, 63, 31, 31, 15, 127);
      send_set(0, 0, 0, 0, 0, 0);
      send_set(60, 60, 24, 29, 2, 100);
      send_set(59, 59, 23, 29, 2, 1);
      send_set(0, 0, 12, 31, 4, 50);
      send_set(0, 0, 11, 30, 4, 50);
      send_set(5, 5, 5, 5, 13, 5);

      program_alarm(6'd0, 6'd0, 6'd1);
      send_set(59, 59, 23, 31, 12, 99);
      send_tick();
      send_set(59, 59, 23, 28, 2, 4);
      send_tick();
      send_tick();
      send_set(59, 59, 23, 29, 2, 4);
      send_tick();
      send_set(59, 59, 23, 28, 2, 5);
      send_tick();
      send_set(59, 59, 23, 30, 4, 7);
      send_tick();
      send_set(59, 58, 10, 15, 6, 20);
      send_tick();
      send_set(59, 59, 11, 15, 6, 20);
      send_tick();

      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               hour_data   = 6'd23;
               minute_data = 6'd59;
               chime_data  = 6'd1;
            end
            1: begin
               hour_data   = 6'd0;
               minute_data = 6'd0;
               chime_data  = 6'd0;
            end
            2: begin
               // Out-of-range alarm: stored but can never match.
               hour_data   = 6'h3F;
               minute_data = 6'd63;
               chime_data  = 6'h3F;
            end
            default: begin
               hour_data   = {1'($urandom_range(0, 1)), 5'($urandom_range(0, 23))};
               minute_data = 6'($urandom_range(0, 59));
               chime_data  = 6'($urandom_range(0, 63));
            end
         endcase
         program_alarm(hour_data, minute_data, chime_data);
         run_random_phase(PHASE_WORDS);
      end

      wait_until_drained();
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("rtc_calendar_counter verification clean");
      end else begin
         $display("rtc_calendar_counter verification failed");
      end
      $finish;
   end
endmodule

// ===== rtc_calendar_counter.f =====
rtl/core/rtc_pkg.sv
rtl/core/rtc_calendar_counter.sv
rtl/core/rtc_checker.sv
tb/tb_rtc_calendar_counter.sv
